>>> rtl/core/http_request_line_url_parser_core_macros.svh
// ----------------------------------------------------------------------------
// http_request_line_url_parser_core_macros
// assertion macros used by the checker file of the url parser core
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_URL_PARSER_CORE_MACROS_SVH
`define HTTP_REQUEST_LINE_URL_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define HRLUP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define HRLUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/hrlup_pkg.sv
// ----------------------------------------------------------------------------
// hrlup_pkg
// constants and types shared by the url parser core modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hrlup_pkg;

    // length and argument limits
    localparam int PATH_MAX  = 64;
    localparam int QUERY_MAX = 128;
    localparam int MAX_ARGS  = 8;

    // depth of the queue between front and back
    localparam int QDEPTH = 2;

    // characters of interest
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_EQUALS  = 8'h3d;
    localparam logic [7:0] CH_QMARK   = 8'h3f;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NUL     = 8'h00;

    // section codes of a result word
    localparam logic [1:0] SEC_PATH  = 2'd0;
    localparam logic [1:0] SEC_NAME  = 2'd1;
    localparam logic [1:0] SEC_VALUE = 2'd2;

    // raw byte class found by the front
    typedef enum logic [2:0] {
        CLS_OTHER,
        CLS_SLASH,
        CLS_NUL,
        CLS_SPACE,
        CLS_QMARK,
        CLS_PERCENT,
        CLS_PLUS
    } cls_t;

    // classified word carried through the queue
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        cls_t       cls;
        logic       hex_ok;
        logic [3:0] nibble;
    } qword_t;

    // head of the queue as seen by the back
    typedef struct packed {
        logic   valid;
        qword_t word;
    } qhead_t;

    // push side of the queue as driven by the front
    typedef struct packed {
        logic   push;
        qword_t word;
    } qpush_t;

endpackage

`default_nettype wire

>>> rtl/core/hrlup_front.sv
// ----------------------------------------------------------------------------
// hrlup_front
// accepts raw request-line bytes and classifies them for the back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlup_front
    import hrlup_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [7:0] line_byte,
    input  wire logic       last_byte,
    input  wire logic       q_full,
    output qpush_t          q_in
);

    logic   hold_valid_reg;
    logic   hold_valid_next;
    qword_t hold_word_reg;
    qword_t word_new;
    logic   accept;
    logic   push;

    always_comb
    begin
        word_new.data   = line_byte;
        word_new.last   = last_byte;
        word_new.hex_ok = 1'b1;
        word_new.nibble = 4'h0;
        unique case (line_byte)
            CH_SLASH:   word_new.cls = CLS_SLASH;
            CH_NUL:     word_new.cls = CLS_NUL;
            CH_SPACE:   word_new.cls = CLS_SPACE;
            CH_QMARK:   word_new.cls = CLS_QMARK;
            CH_PERCENT: word_new.cls = CLS_PERCENT;
            CH_PLUS:    word_new.cls = CLS_PLUS;
            default:    word_new.cls = CLS_OTHER;
        endcase
        // hex digit, case ignored; a non-digit gives nibble zero
        if (line_byte >= 8'h30 && line_byte <= 8'h39)
        begin
            word_new.nibble = 4'(line_byte - 8'h30);
        end
        else if (line_byte >= 8'h61 && line_byte <= 8'h66)
        begin
            word_new.nibble = 4'(line_byte - 8'h57);
        end
        else if (line_byte >= 8'h41 && line_byte <= 8'h46)
        begin
            word_new.nibble = 4'(line_byte - 8'h37);
        end
        else
        begin
            word_new.hex_ok = 1'b0;
        end
    end

    assign push      = hold_valid_reg && !q_full;
    assign req_stall = hold_valid_reg && q_full;
    assign accept    = req_valid && !req_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (accept)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_word_reg <= word_new;
        end
    end

    assign q_in.push = push;
    assign q_in.word = hold_word_reg;

endmodule

`default_nettype wire

>>> rtl/core/hrlup_queue.sv
// ----------------------------------------------------------------------------
// hrlup_queue
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlup_queue
    import hrlup_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qpush_t q_in,
    output logic        q_full,
    input  wire logic   q_pop,
    output qhead_t      q_head
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    qword_t             mem [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign q_full  = (count_reg == CNT_W'(QDEPTH));
    assign do_push = q_in.push && !q_full;
    assign do_pop  = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= q_in.word;
        end
    end

    assign q_head.valid = (count_reg != '0);
    assign q_head.word  = mem[rd_ptr_reg];

endmodule

`default_nettype wire

>>> rtl/core/hrlup_back.sv
// ----------------------------------------------------------------------------
// hrlup_back
// scan state machine: percent decode, field split and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hrlup_back
    import hrlup_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire qhead_t q_head,
    output logic        q_pop,
    output logic        res_valid,
    input  wire logic   res_stall,
    output logic [1:0]  section,
    output logic [3:0]  arg_index,
    output logic        byte_valid,
    output logic [7:0]  data_byte,
    output logic        field_end,
    output logic        line_end,
    output logic        path_empty,
    output logic        truncated,
    output logic        args_dropped,
    output logic [4:0]  arg_total
);

    typedef enum logic [3:0] {
        PH_SEEK,
        PH_PATH,
        PH_PATH_HEX1,
        PH_PATH_HEX2,
        PH_QUERY,
        PH_QUERY_HEX1,
        PH_QUERY_HEX2,
        PH_DISCARD,
        PH_DONE
    } phase_t;

    phase_t       phase_reg, phase_next;
    logic [3:0]   hex_high_reg, hex_high_next;
    logic         hex_ok_reg, hex_ok_next;
    logic [7:0]   path_len_reg, path_len_next;
    logic [7:0]   query_len_reg, query_len_next;
    logic [4:0]   arg_num_reg, arg_num_next;
    logic         in_value_reg, in_value_next;
    logic         trunc_reg, trunc_next;
    logic         drop_reg, drop_next;
    logic         clr;

    logic         res_valid_reg;
    logic [1:0]   section_reg;
    logic [3:0]   arg_index_reg;
    logic         byte_valid_reg;
    logic [7:0]   data_byte_reg;
    logic         field_end_reg;
    logic         line_end_reg;
    logic         path_empty_reg;
    logic         truncated_reg;
    logic         args_dropped_reg;
    logic [4:0]   arg_total_reg;

    qword_t       w;
    logic         term;
    logic [7:0]   hex_fin;
    logic [1:0]   cur_sec;
    logic [3:0]   cur_idx;
    logic         p_req, q_req;
    logic [7:0]   p_val, q_val;
    logic [4:0]   an;
    logic         iv;
    logic         em, em_bv, em_fe, em_le;
    logic [1:0]   em_sec;
    logic [3:0]   em_idx;
    logic [7:0]   em_db;

    assign w     = q_head.word;
    assign q_pop = q_head.valid && (!res_valid_reg || !res_stall);
    assign term  = (w.cls == CLS_SPACE) || (w.cls == CLS_NUL);

    always_comb
    begin
        // partial hex: two digits, first digit only, or zero
        if (!hex_ok_reg)
        begin
            hex_fin = 8'h00;
        end
        else if (w.hex_ok)
        begin
            hex_fin = {hex_high_reg, w.nibble};
        end
        else
        begin
            hex_fin = {4'h0, hex_high_reg};
        end
        cur_sec = in_value_reg ? SEC_VALUE : SEC_NAME;
        cur_idx = (arg_num_reg == '0) ? 4'h0 : 4'(arg_num_reg - 5'd1);
    end

    always_comb
    begin
        phase_next     = phase_reg;
        hex_high_next  = hex_high_reg;
        hex_ok_next    = hex_ok_reg;
        path_len_next  = path_len_reg;
        query_len_next = query_len_reg;
        arg_num_next   = arg_num_reg;
        in_value_next  = in_value_reg;
        trunc_next     = trunc_reg;
        drop_next      = drop_reg;
        clr            = 1'b0;
        p_req          = 1'b0;
        p_val          = w.data;
        q_req          = 1'b0;
        q_val          = w.data;
        an             = (arg_num_reg == '0) ? 5'd1 : arg_num_reg;
        iv             = (arg_num_reg == '0) ? 1'b0 : in_value_reg;
        em             = 1'b0;
        em_sec         = SEC_PATH;
        em_idx         = 4'h0;
        em_bv          = 1'b0;
        em_db          = 8'h00;
        em_fe          = 1'b0;
        em_le          = 1'b0;

        if (w.last)
        begin
            // final byte: close what is open, then back to reset state
            clr   = 1'b1;
            em    = 1'b1;
            em_le = 1'b1;
            unique case (phase_reg)
                PH_SEEK, PH_PATH, PH_PATH_HEX1, PH_PATH_HEX2:
                begin
                    em_fe = 1'b1;
                end
                PH_QUERY, PH_QUERY_HEX1, PH_QUERY_HEX2:
                begin
                    if (arg_num_reg != '0)
                    begin
                        em_fe  = 1'b1;
                        em_sec = cur_sec;
                        em_idx = cur_idx;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (phase_reg)
                PH_SEEK:
                begin
                    if (w.cls == CLS_SLASH)
                    begin
                        phase_next = PH_PATH;
                    end
                    else if (w.cls == CLS_NUL)
                    begin
                        phase_next = PH_DONE;
                        em         = 1'b1;
                        em_fe      = 1'b1;
                    end
                end
                PH_PATH:
                begin
                    if (term)
                    begin
                        phase_next = PH_DONE;
                        em         = 1'b1;
                        em_fe      = 1'b1;
                    end
                    else if (w.cls == CLS_QMARK)
                    begin
                        phase_next = PH_QUERY;
                        em         = 1'b1;
                        em_fe      = 1'b1;
                    end
                    else if (w.cls == CLS_PERCENT)
                    begin
                        phase_next = PH_PATH_HEX1;
                    end
                    else
                    begin
                        p_req = 1'b1;
                    end
                end
                PH_PATH_HEX1, PH_QUERY_HEX1:
                begin
                    hex_high_next = w.nibble;
                    hex_ok_next   = w.hex_ok;
                    phase_next    = (phase_reg == PH_PATH_HEX1) ? PH_PATH_HEX2 : PH_QUERY_HEX2;
                end
                PH_PATH_HEX2:
                begin
                    phase_next = PH_PATH;
                    p_req      = 1'b1;
                    p_val      = hex_fin;
                end
                PH_QUERY:
                begin
                    if (term)
                    begin
                        phase_next = PH_DONE;
                        if (arg_num_reg != '0)
                        begin
                            em     = 1'b1;
                            em_fe  = 1'b1;
                            em_sec = cur_sec;
                            em_idx = cur_idx;
                        end
                    end
                    else if (w.cls == CLS_PERCENT)
                    begin
                        phase_next = PH_QUERY_HEX1;
                    end
                    else
                    begin
                        q_req = 1'b1;
                        q_val = (w.cls == CLS_PLUS) ? CH_SPACE : w.data;
                    end
                end
                PH_QUERY_HEX2:
                begin
                    phase_next = PH_QUERY;
                    q_req      = 1'b1;
                    q_val      = hex_fin;
                end
                PH_DISCARD:
                begin
                    if (term)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // decoded path byte
        if (p_req)
        begin
            if (path_len_reg >= 8'(PATH_MAX))
            begin
                trunc_next = 1'b1;
            end
            else
            begin
                path_len_next = path_len_reg + 8'd1;
                em            = 1'b1;
                em_bv         = 1'b1;
                em_db         = p_val;
            end
        end

        // decoded query byte
        if (q_req)
        begin
            if (query_len_reg >= 8'(QUERY_MAX))
            begin
                trunc_next = 1'b1;
            end
            else
            begin
                query_len_next = query_len_reg + 8'd1;
                arg_num_next   = an;
                in_value_next  = iv;
                em             = 1'b1;
                em_idx         = 4'(an - 5'd1);
                if (q_val == CH_AMP)
                begin
                    em_fe  = 1'b1;
                    em_sec = iv ? SEC_VALUE : SEC_NAME;
                    if (an < 5'(MAX_ARGS))
                    begin
                        arg_num_next  = an + 5'd1;
                        in_value_next = 1'b0;
                    end
                    else
                    begin
                        drop_next  = 1'b1;
                        phase_next = PH_DISCARD;
                    end
                end
                else if (q_val == CH_EQUALS && !iv)
                begin
                    in_value_next = 1'b1;
                    em_fe         = 1'b1;
                    em_sec        = SEC_NAME;
                end
                else
                begin
                    em_sec = iv ? SEC_VALUE : SEC_NAME;
                    em_bv  = 1'b1;
                    em_db  = q_val;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEEK;
            hex_high_reg  <= 4'h0;
            hex_ok_reg    <= 1'b0;
            path_len_reg  <= 8'd0;
            query_len_reg <= 8'd0;
            arg_num_reg   <= 5'd0;
            in_value_reg  <= 1'b0;
            trunc_reg     <= 1'b0;
            drop_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                if (clr)
                begin
                    phase_reg     <= PH_SEEK;
                    hex_high_reg  <= 4'h0;
                    hex_ok_reg    <= 1'b0;
                    path_len_reg  <= 8'd0;
                    query_len_reg <= 8'd0;
                    arg_num_reg   <= 5'd0;
                    in_value_reg  <= 1'b0;
                    trunc_reg     <= 1'b0;
                    drop_reg      <= 1'b0;
                end
                else
                begin
                    phase_reg     <= phase_next;
                    hex_high_reg  <= hex_high_next;
                    hex_ok_reg    <= hex_ok_next;
                    path_len_reg  <= path_len_next;
                    query_len_reg <= query_len_next;
                    arg_num_reg   <= arg_num_next;
                    in_value_reg  <= in_value_next;
                    trunc_reg     <= trunc_next;
                    drop_reg      <= drop_next;
                end
            end
            if (q_pop && em)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && em)
        begin
            section_reg      <= em_sec;
            arg_index_reg    <= em_idx;
            byte_valid_reg   <= em_bv;
            data_byte_reg    <= em_db;
            field_end_reg    <= em_fe;
            line_end_reg     <= em_le;
            path_empty_reg   <= (path_len_next == 8'd0);
            truncated_reg    <= trunc_next;
            args_dropped_reg <= drop_next;
            arg_total_reg    <= em_le ? arg_num_next : 5'd0;
        end
    end

    assign res_valid    = res_valid_reg;
    assign section      = section_reg;
    assign arg_index    = arg_index_reg;
    assign byte_valid   = byte_valid_reg;
    assign data_byte    = data_byte_reg;
    assign field_end    = field_end_reg;
    assign line_end     = line_end_reg;
    assign path_empty   = path_empty_reg;
    assign truncated    = truncated_reg;
    assign args_dropped = args_dropped_reg;
    assign arg_total    = arg_total_reg;

endmodule

`default_nettype wire

>>> rtl/core/http_request_line_url_parser_core.sv
// a byte accepted by the front passes its holding register and the queue before the back registers its result word
// throughput: one byte per cycle while the result channel is not stalled, set by the scan step in the back
// a byte that produces no result still takes a scan step in the back and leaves no word
// reset: rst_n asynchronous active low, scan returns to seeking the first slash
// the final byte of a line also returns all scan state to its reset value
// ----------------------------------------------------------------------------
// http_request_line_url_parser_core
// percent-decoding url parser for an http request line, one byte per word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_url_parser_core
    import hrlup_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // request byte channel
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire logic [7:0] line_byte,
    input  wire logic       last_byte,
    // result channel
    output logic            res_valid,
    input  wire logic       res_stall,
    output logic [1:0]      section,
    output logic [3:0]      arg_index,
    output logic            byte_valid,
    output logic [7:0]      data_byte,
    output logic            field_end,
    output logic            line_end,
    output logic            path_empty,
    output logic            truncated,
    output logic            args_dropped,
    output logic [4:0]      arg_total
);

    // front to queue: classified word and push
    qpush_t q_in;
    // queue back-pressure to the front
    logic   q_full;
    // queue head to the back and its pop
    qhead_t q_head;
    logic   q_pop;

    // front: holding register, byte class and hex nibble per word
    hrlup_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .line_byte (line_byte),
        .last_byte (last_byte),
        .q_full    (q_full),
        .q_in      (q_in)
    );

    // queue: lets the front keep taking bytes while the result side stalls
    hrlup_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_in   (q_in),
        .q_full (q_full),
        .q_pop  (q_pop),
        .q_head (q_head)
    );

    // back: scan state machine, length limits, argument split, result register
    hrlup_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .section      (section),
        .arg_index    (arg_index),
        .byte_valid   (byte_valid),
        .data_byte    (data_byte),
        .field_end    (field_end),
        .line_end     (line_end),
        .path_empty   (path_empty),
        .truncated    (truncated),
        .args_dropped (args_dropped),
        .arg_total    (arg_total)
    );

endmodule

`default_nettype wire

>>> rtl/core/hrlup_checker.sv
// ----------------------------------------------------------------------------
// hrlup_checker
// port-level checks on the result words of the url parser core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "http_request_line_url_parser_core_macros.svh"

module hrlup_checker
    import hrlup_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_valid,
    input  wire logic       res_stall,
    input  wire logic [1:0] section,
    input  wire logic [3:0] arg_index,
    input  wire logic       byte_valid,
    input  wire logic [7:0] data_byte,
    input  wire logic       field_end,
    input  wire logic       line_end,
    input  wire logic [4:0] arg_total
);

    // stalled result word holds
    `HRLUP_ASSERT_NEXT(a_res_hold, res_valid && res_stall,
        res_valid && $stable(data_byte) && $stable(section) && $stable(line_end),
        "result word changed while stalled")

    // no data byte without byte_valid
    `HRLUP_ASSERT_NOW(a_byte_zero, res_valid && !byte_valid, data_byte == 8'h00,
        "data_byte set without byte_valid")

    // argument count only on the line end word
    `HRLUP_ASSERT_NOW(a_total_end, res_valid && !line_end, arg_total == 5'd0,
        "arg_total set before line end")

    // path words carry argument index zero and never both data and field end
    `HRLUP_ASSERT_NOW(a_path_index, res_valid && section == SEC_PATH,
        arg_index == 4'd0 && !(byte_valid && field_end),
        "path word with argument index or data and field end")

endmodule

bind http_request_line_url_parser_core hrlup_checker u_hrlup_checker (.*);

`default_nettype wire

>>> bench/http_request_line_url_parser_core_test.sv
// ----------------------------------------------------------------------------
// http_request_line_url_parser_core_test
// self-checking bench: request lines are fed in one byte per word; result words
// are compared with a behavioural model of the scan held here or a typed table row,
// under four idling phases, a long receiver hold-off and full drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module http_request_line_url_parser_core_test;
    import hrlup_pkg::*;

    // run length and timing
    localparam int  PHASE_ITEMS = 140;     // request bytes per idling phase
    localparam int  TAIL_CYCLES = 8;       // settling margin after the last owed word
    localparam int  HOLD_CYCLES = 300;     // long receiver hold-off
    localparam real RUN_LIMIT   = 400000.0;

    // characters used by the hex decode and the line builder
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;

    // scan phases of the behavioural model, ordered so that query and later
    // phases compare above the path phases
    typedef enum logic [3:0] {
        SCAN_SEEK,
        SCAN_PATH,
        SCAN_PATH_HI,
        SCAN_PATH_LO,
        SCAN_QUERY,
        SCAN_QUERY_HI,
        SCAN_QUERY_LO,
        SCAN_DISCARD,
        SCAN_DONE
    } scan_phase_t;

    // shapes of generated request line
    typedef enum logic [2:0] {
        LINE_PLAIN,
        LINE_LONG_PATH,
        LINE_LONG_QUERY,
        LINE_MANY_ARGS,
        LINE_NOISE,
        LINE_BROKEN
    } line_kind_t;

    // one result word as the block presents it
    typedef struct packed {
        logic [1:0] section;
        logic [3:0] arg_index;
        logic       byte_valid;
        logic [7:0] data_byte;
        logic       field_end;
        logic       line_end;
        logic       path_empty;
        logic       truncated;
        logic       args_dropped;
        logic [4:0] arg_total;
    } url_word_t;

    // one row of the directed table
    typedef struct packed {
        logic [7:0] line_byte;
        logic       last_byte;
        logic       typed;
        url_word_t  word;
    } plan_row_t;

    // dut ports, inputs known from time zero
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       req_valid = 1'b0;
    logic       req_stall;
    logic [7:0] line_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] section;
    logic [3:0] arg_index;
    logic       byte_valid;
    logic [7:0] data_byte;
    logic       field_end;
    logic       line_end;
    logic       path_empty;
    logic       truncated;
    logic       args_dropped;
    logic [4:0] arg_total;

    // model state, mirrors the scan of the block
    scan_phase_t scan_ph = SCAN_SEEK;
    logic [3:0]  hex_hi = 4'h0;
    logic        hex_hi_ok = 1'b0;
    logic [7:0]  path_count = 8'h00;
    logic [7:0]  query_count = 8'h00;
    logic [4:0]  arg_count = 5'd0;
    logic        value_side = 1'b0;
    logic [1:0]  sticky = 2'b00;

    // words still owed by the block, oldest first
    url_word_t expected_words [$];

    // typed expectation that travels with the word on the request channel
    logic      typed_next = 1'b0;
    url_word_t typed_word = '0;

    // directed table and the line being built
    plan_row_t  plan_q [$];
    logic [7:0] line_q [$];

    // idling control
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    // bookkeeping
    int mismatches = 0;
    int words_checked = 0;
    int bytes_sent = 0;
    int lines_sent = 0;
    int trunc_seen = 0;
    int drop_seen = 0;
    int empty_seen = 0;

    http_request_line_url_parser_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .line_byte    (line_byte),
        .last_byte    (last_byte),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .section      (section),
        .arg_index    (arg_index),
        .byte_valid   (byte_valid),
        .data_byte    (data_byte),
        .field_end    (field_end),
        .line_end     (line_end),
        .path_empty   (path_empty),
        .truncated    (truncated),
        .args_dropped (args_dropped),
        .arg_total    (arg_total)
    );

    // 2 ns clock
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // behavioural model of the scan
    // ------------------------------------------------------------------

    // hex digit value, 16 when the byte is not a digit (either case)
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return {1'b0, c[3:0]};
        if ((c >= CH_LOWER_A && c <= CH_LOWER_F) || (c >= CH_UPPER_A && c <= CH_UPPER_F))
            return 5'(c[3:0] + 4'd9);
        return 5'd16;
    endfunction

    function automatic void clear_scan();
        scan_ph     = SCAN_SEEK;
        hex_hi      = 4'h0;
        hex_hi_ok   = 1'b0;
        path_count  = 8'h00;
        query_count = 8'h00;
        arg_count   = 5'd0;
        value_side  = 1'b0;
        sticky      = 2'b00;
    endfunction

    function automatic logic [1:0] field_section();
        return value_side ? SEC_VALUE : SEC_NAME;
    endfunction

    function automatic logic [3:0] field_index();
        return (arg_count > 0) ? 4'(arg_count - 5'd1) : 4'd0;
    endfunction

    // word as the block would present it from the current state
    function automatic url_word_t make_word(input logic [1:0] sec, input logic [3:0] idx,
                                            input logic bv, input logic [7:0] d,
                                            input logic fe, input logic le);
        url_word_t w;
        w.section      = sec;
        w.arg_index    = idx;
        w.byte_valid   = bv;
        w.data_byte    = bv ? d : 8'h00;
        w.field_end    = fe;
        w.line_end     = le;
        w.path_empty   = (scan_ph >= SCAN_QUERY) && (path_count == 8'h00);
        w.truncated    = sticky[0];
        w.args_dropped = sticky[1];
        w.arg_total    = le ? arg_count : 5'd0;
        return w;
    endfunction

    // first byte after a percent sign
    function automatic void hex_begin(input logic [7:0] c);
        logic [4:0] v;
        v         = hex_value(c);
        hex_hi_ok = (v != 5'd16);
        hex_hi    = v[3:0];
    endfunction

    // second byte after a percent sign, with partial hex falling back
    function automatic logic [7:0] hex_join(input logic [7:0] c);
        logic [4:0] lo;
        lo = hex_value(c);
        if (!hex_hi_ok)
            return 8'h00;
        if (lo != 5'd16)
            return {hex_hi, lo[3:0]};
        return {4'h0, hex_hi};
    endfunction

    function automatic bit path_keep(input logic [7:0] v, output url_word_t w);
        w = '0;
        if (path_count >= PATH_MAX)
        begin
            sticky[0] = 1'b1;
            return 1'b0;
        end
        path_count = path_count + 8'd1;
        w = make_word(SEC_PATH, 4'd0, 1'b1, v, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    function automatic bit query_keep(input logic [7:0] v, output url_word_t w);
        logic [1:0] sec;
        logic [3:0] idx;
        w = '0;
        if (query_count >= QUERY_MAX)
        begin
            sticky[0] = 1'b1;
            return 1'b0;
        end
        query_count = query_count + 8'd1;
        if (arg_count == 5'd0)
        begin
            arg_count  = 5'd1;
            value_side = 1'b0;
        end
        if (v == CH_AMP)
        begin
            sec = field_section();
            idx = field_index();
            if (arg_count < MAX_ARGS)
            begin
                arg_count  = arg_count + 5'd1;
                value_side = 1'b0;
            end
            else
            begin
                sticky[1] = 1'b1;
                scan_ph   = SCAN_DISCARD;
            end
            w = make_word(sec, idx, 1'b0, 8'h00, 1'b1, 1'b0);
            return 1'b1;
        end
        if (v == CH_EQUALS && !value_side)
        begin
            value_side = 1'b1;
            w = make_word(SEC_NAME, field_index(), 1'b0, 8'h00, 1'b1, 1'b0);
            return 1'b1;
        end
        w = make_word(field_section(), field_index(), 1'b1, v, 1'b0, 1'b0);
        return 1'b1;
    endfunction

    // one accepted request word; returns 1 when it owes a result word
    function automatic bit decode_url_byte(input logic [7:0] b, input logic l,
                                           output url_word_t w);
        w = '0;
        if (l)
        begin
            // the final byte closes whatever field is open
            case (scan_ph)
                SCAN_SEEK, SCAN_PATH, SCAN_PATH_HI, SCAN_PATH_LO:
                begin
                    scan_ph = SCAN_DONE;
                    w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b1, 1'b1);
                end
                SCAN_QUERY, SCAN_QUERY_HI, SCAN_QUERY_LO:
                begin
                    scan_ph = SCAN_DONE;
                    if (arg_count > 0)
                        w = make_word(field_section(), field_index(), 1'b0, 8'h00, 1'b1, 1'b1);
                    else
                        w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b0, 1'b1);
                end
                default:
                begin
                    scan_ph = SCAN_DONE;
                    w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b0, 1'b1);
                end
            endcase
            clear_scan();
            return 1'b1;
        end
        case (scan_ph)
            SCAN_SEEK:
            begin
                if (b == CH_SLASH)
                    scan_ph = SCAN_PATH;
                else if (b == CH_NUL)
                begin
                    scan_ph = SCAN_DONE;
                    w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b1, 1'b0);
                    return 1'b1;
                end
                return 1'b0;
            end
            SCAN_PATH:
            begin
                if (b == CH_SPACE || b == CH_NUL)
                begin
                    scan_ph = SCAN_DONE;
                    w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b1, 1'b0);
                    return 1'b1;
                end
                if (b == CH_QMARK)
                begin
                    scan_ph = SCAN_QUERY;
                    w = make_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b1, 1'b0);
                    return 1'b1;
                end
                if (b == CH_PERCENT)
                begin
                    scan_ph = SCAN_PATH_HI;
                    return 1'b0;
                end
                return path_keep(b, w);
            end
            SCAN_PATH_HI:
            begin
                hex_begin(b);
                scan_ph = SCAN_PATH_LO;
                return 1'b0;
            end
            SCAN_PATH_LO:
            begin
                scan_ph = SCAN_PATH;
                return path_keep(hex_join(b), w);
            end
            SCAN_QUERY:
            begin
                if (b == CH_SPACE || b == CH_NUL)
                begin
                    scan_ph = SCAN_DONE;
                    if (arg_count > 0)
                    begin
                        w = make_word(field_section(), field_index(), 1'b0, 8'h00, 1'b1, 1'b0);
                        return 1'b1;
                    end
                    return 1'b0;
                end
                if (b == CH_PERCENT)
                begin
                    scan_ph = SCAN_QUERY_HI;
                    return 1'b0;
                end
                if (b == CH_PLUS)
                    return query_keep(CH_SPACE, w);
                return query_keep(b, w);
            end
            SCAN_QUERY_HI:
            begin
                hex_begin(b);
                scan_ph = SCAN_QUERY_LO;
                return 1'b0;
            end
            SCAN_QUERY_LO:
            begin
                scan_ph = SCAN_QUERY;
                return query_keep(hex_join(b), w);
            end
            SCAN_DISCARD:
            begin
                if (b == CH_SPACE || b == CH_NUL)
                    scan_ph = SCAN_DONE;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // checking, sampled at the rising edge
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        url_word_t w;
        url_word_t want;
        bit        owed;
        if (rst_n)
        begin
            // result side: compare with the oldest word owed
            if (res_valid && !res_stall)
            begin
                words_checked++;
                if (truncated === 1'b1) trunc_seen++;
                if (args_dropped === 1'b1) drop_seen++;
                if (path_empty === 1'b1) empty_seen++;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing owed: section %0d data 0x%0h",
                           section, data_byte);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("section", 8'(want.section), 8'(section));
                    check_field("arg_index", 8'(want.arg_index), 8'(arg_index));
                    check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid));
                    check_field("data_byte", want.data_byte, data_byte);
                    check_field("field_end", 8'(want.field_end), 8'(field_end));
                    check_field("line_end", 8'(want.line_end), 8'(line_end));
                    check_field("path_empty", 8'(want.path_empty), 8'(path_empty));
                    check_field("truncated", 8'(want.truncated), 8'(truncated));
                    check_field("args_dropped", 8'(want.args_dropped), 8'(args_dropped));
                    check_field("arg_total", 8'(want.arg_total), 8'(arg_total));
                end
            end
            // request side: run the model on every accepted byte
            if (req_valid && !req_stall)
            begin
                bytes_sent++;
                owed = decode_url_byte(line_byte, last_byte, w);
                if (typed_next)
                    expected_words.push_back(typed_word);
                else if (owed)
                    expected_words.push_back(w);
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, or a counted hold-off when asked for
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            res_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            res_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // sender helpers, entered and left at a falling edge
    // ------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        line_byte = b;
        last_byte = l;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // sender pauses until every owed word is back, then lets the pipe settle
    task automatic drain_results();
        req_valid = 1'b0;
        while (expected_words.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------

    function automatic url_word_t known_word(input logic [1:0] sec, input logic [3:0] idx,
                                             input logic bv, input logic [7:0] d,
                                             input logic fe, input logic le, input logic pe);
        url_word_t w;
        w            = '0;
        w.section    = sec;
        w.arg_index  = idx;
        w.byte_valid = bv;
        w.data_byte  = d;
        w.field_end  = fe;
        w.line_end   = le;
        w.path_empty = pe;
        return w;
    endfunction

    function automatic void plan_row(input logic [7:0] b, input logic l, input logic typed,
                                     input url_word_t w);
        plan_row_t r;
        r.line_byte = b;
        r.last_byte = l;
        r.typed     = typed;
        r.word      = w;
        plan_q.push_back(r);
    endfunction

    function automatic void plan_text(input string s);
        for (int i = 0; i < s.len(); i++)
            plan_row(s[i], 1'b0, 1'b0, '0);
    endfunction

    function automatic void build_plan();
        // nul before the slash: empty path straight after reset, rest ignored
        plan_row(CH_NUL, 1'b0, 1'b1,
                 known_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b1, 1'b0, 1'b1));
        plan_text("x");
        plan_row(8'hff, 1'b1, 1'b1,
                 known_word(SEC_PATH, 4'd0, 1'b0, 8'h00, 1'b0, 1'b1, 1'b1));
        // full escape to the top byte value
        plan_text("G/%f");
        plan_row("F", 1'b0, 1'b1,
                 known_word(SEC_PATH, 4'd0, 1'b1, 8'hff, 1'b0, 1'b0, 1'b0));
        // partial hex: first digit only, then neither
        plan_text("%4z%g1");
        // into the query: escaped ampersand splits, raw plus becomes space,
        // escaped plus stays a plus
        plan_text("?%26a=+%2B");
        plan_row(CH_NUL, 1'b1, 1'b0, '0);
    endfunction

    // ------------------------------------------------------------------
    // random request lines
    // ------------------------------------------------------------------

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            line_q.push_back(s[i]);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
            return CH_ZERO + 8'(d);
        return ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(d) - 8'd10;
    endfunction

    // percent escape, mostly real digits but now and then any byte at all
    function automatic void add_escape();
        line_q.push_back(CH_PERCENT);
        repeat (2)
        begin
            if ($urandom_range(9) < 7)
                line_q.push_back(hex_char(4'($urandom_range(15))));
            else
                line_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    function automatic void add_coded(input logic [7:0] c);
        line_q.push_back(CH_PERCENT);
        line_q.push_back(hex_char(c[7:4]));
        line_q.push_back(hex_char(c[3:0]));
    endfunction

    function automatic logic [7:0] text_char();
        string set;
        set = "abcmxyzABCMXYZ0189-._~";
        return set[$urandom_range(set.len() - 1)];
    endfunction

    function automatic void add_path_char();
        int r;
        r = $urandom_range(99);
        if (r < 10)
            add_escape();
        else if (r < 14)
            line_q.push_back(CH_SLASH);
        else if (r < 17)
            line_q.push_back($urandom_range(1) ? CH_AMP : CH_EQUALS);
        else if (r < 19)
            line_q.push_back(CH_PLUS);
        else
            line_q.push_back(text_char());
    endfunction

    function automatic void add_query_char();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            add_escape();
        else if (r < 10)
            add_coded($urandom_range(1) ? CH_EQUALS : CH_PLUS);
        else if (r < 15)
            line_q.push_back(CH_PLUS);
        else if (r < 17)
            line_q.push_back(CH_QMARK);
        else if (r < 19)
            line_q.push_back(CH_EQUALS);
        else
            line_q.push_back(text_char());
    endfunction

    function automatic void build_line(input line_kind_t kind);
        int plen;
        int nargs;
        int vmin;
        int vmax;
        line_q.delete();
        if (kind == LINE_NOISE)
        begin
            repeat ($urandom_range(1, 24)) line_q.push_back(8'($urandom_range(255)));
            return;
        end
        case ($urandom_range(3))
            0: add_text("GET ");
            1: add_text("POST ");
            2: add_text("  x");
            default: ;
        endcase
        line_q.push_back(CH_SLASH);
        plen = (kind == LINE_LONG_PATH) ? $urandom_range(66, 80) : $urandom_range(0, 12);
        repeat (plen) add_path_char();
        if (kind inside {LINE_LONG_QUERY, LINE_MANY_ARGS} || $urandom_range(3) != 0)
        begin
            line_q.push_back(CH_QMARK);
            nargs = (kind == LINE_MANY_ARGS) ? $urandom_range(9, 12) :
                    (kind == LINE_LONG_QUERY) ? 3 : $urandom_range(0, 4);
            vmin  = (kind == LINE_LONG_QUERY) ? 45 : 0;
            vmax  = (kind == LINE_LONG_QUERY) ? 55 : 6;
            for (int a = 0; a < nargs; a++)
            begin
                if (a > 0)
                begin
                    if ($urandom_range(4) == 0)
                        add_coded(CH_AMP);
                    else
                        line_q.push_back(CH_AMP);
                end
                repeat ($urandom_range(0, 4)) line_q.push_back(text_char());
                if ($urandom_range(4) != 0)
                begin
                    line_q.push_back(CH_EQUALS);
                    repeat ($urandom_range(vmin, vmax)) add_query_char();
                end
            end
        end
        if (kind == LINE_BROKEN)
        begin
            // line cut short inside an escape
            line_q.push_back(CH_PERCENT);
            if ($urandom_range(1))
                line_q.push_back(hex_char(4'($urandom_range(15))));
            return;
        end
        case ($urandom_range(3))
            0: add_text(" HTTP/1.1\r");
            1:
            begin
                line_q.push_back(CH_NUL);
                add_text("zz");
            end
            2: line_q.push_back(CH_SPACE);
            default: ;
        endcase
    endfunction

    function automatic line_kind_t pick_kind();
        int r;
        r = $urandom_range(99);
        if (r < 4)  return LINE_LONG_PATH;
        if (r < 7)  return LINE_LONG_QUERY;
        if (r < 12) return LINE_MANY_ARGS;
        if (r < 20) return LINE_NOISE;
        if (r < 28) return LINE_BROKEN;
        return LINE_PLAIN;
    endfunction

    task automatic send_line(input line_kind_t kind);
        build_line(kind);
        foreach (line_q[i])
            push_byte(line_q[i], 1'b0);
        // final byte value is a don't-care terminator
        push_byte(8'($urandom_range(255)), 1'b1);
        lines_sent++;
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial
    begin
        int         phase_start;
        line_kind_t first_kind [4];
        int         idle_of [4];
        int         stall_of [4];
        first_kind = '{LINE_LONG_PATH, LINE_LONG_QUERY, LINE_MANY_ARGS, LINE_BROKEN};
        // sender idle and receiver stall per phase
        idle_of    = '{0, 52, 0, 25};
        stall_of   = '{0, 0, 52, 25};

        clear_scan();
        repeat (3) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed part, no idling
        build_plan();
        foreach (plan_q[i])
        begin
            typed_next = plan_q[i].typed;
            typed_word = plan_q[i].word;
            push_byte(plan_q[i].line_byte, plan_q[i].last_byte);
        end
        typed_next = 1'b0;
        drain_results();

        // random part in four idling phases, drained between them
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_of[p];
            recv_stall_pct = stall_of[p];
            phase_start    = bytes_sent;
            if (p == 0)
            begin
                // receiver holds off while the sender keeps offering
                @(posedge clk);
                hold_request = HOLD_CYCLES;
                @(negedge clk);
            end
            send_line(first_kind[p]);
            while (bytes_sent - phase_start < PHASE_ITEMS)
                send_line(pick_kind());
            drain_results();
        end

        $display("run covered %0d lines, %0d bytes, %0d result words checked",
                 lines_sent, bytes_sent, words_checked);
        $display("words flagged: truncated %0d, args dropped %0d, empty path %0d",
                 trunc_seen, drop_seen, empty_seen);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("http_request_line_url_parser_core_test passed");
        else
            $display("http_request_line_url_parser_core_test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #(RUN_LIMIT);
        $display("http_request_line_url_parser_core_test failed");
        $finish;
    end

endmodule

`default_nettype wire
